[src/kmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KMP prefix function package
// Shared widths, store depth and sequencer state codes.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Depth of the text store and border table
    localparam int MAX_LEN_INT = 4096;

    localparam int SYM_W    = 8;
    localparam int ADDR_W   = $clog2(MAX_LEN_INT);
    localparam int BORDER_W = 12;
    localparam int LEN_W    = 13;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEN_INT);

    typedef logic [SYM_W-1:0]    sym_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [BORDER_W-1:0] border_t;
    typedef logic [LEN_W-1:0]    len_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

[src/kmp_prefix_function.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KMP prefix function
// Computes the longest proper border of each prefix of a byte string online.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transfer carries one byte in
//   symbol; start_new set makes it the first byte of a new string. The first
//   byte after reset always opens a string.
//   Output channel (out_valid / out_stall): exactly one transfer per input
//   byte, in order, with border_length, the one-based position and overflow.
//   Once a string holds MAX_LEN bytes, later bytes are dropped and report
//   border_length 0, position 0, overflow 1 until start_new.
// Timing:
//   A byte that opens a string, or that overflows, goes from accept
//   straight to hand-off (ST_DONE). Any other byte runs P probes of the
//   stored table first: each probe is one registered read of the text
//   store and border table (ST_READ) followed by a compare (ST_CMP),
//   through a single shared compare/fallback unit. P is at most one plus
//   the number of fallbacks; fallbacks amortize to at most one per byte.
//   in_stall is high while a byte is in flight; the next byte is taken as
//   soon as the sequencer is back in idle, even if a result still waits in
//   the output register.
// Reset: clears the sequencer, the string length, the current border and out_valid.
//   The stores are not cleared; only entries of the current string are used.
// Receiver stall: the result holds in the output register; a finished
//   result behind it waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module kmp_prefix_function
    import kmp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SYM_W-1:0]    symbol,
    input  logic                start_new,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BORDER_W-1:0] border_length,
    output logic [LEN_W-1:0]    position,
    output logic                overflow
);

    // Stores: no reset, written once per stored byte
    sym_t    text_mem   [MAX_LEN_INT];
    border_t border_mem [MAX_LEN_INT];

    state_t  state_reg, state_next;
    len_t    len_reg, len_next;
    border_t cb_reg, cb_next;
    border_t t_reg, t_next;
    sym_t    sym_reg, sym_next;

    // Registered read data of the current probe
    sym_t    text_rd_reg;
    border_t border_rd_reg;

    // Finished result waiting for the output register
    border_t res_border_reg, res_border_next;
    len_t    res_pos_reg, res_pos_next;
    logic    res_ovf_reg, res_ovf_next;

    // Output register
    logic    out_valid_reg, out_valid_next;
    border_t out_border_reg;
    len_t    out_pos_reg;
    logic    out_ovf_reg;

    // Store write port
    logic    mem_we;
    addr_t   wr_addr;
    sym_t    wr_sym;
    border_t wr_border;

    logic    in_xfer;
    logic    out_xfer;
    logic    out_free;
    len_t    len_eff;
    border_t cb_eff;
    logic    match;
    border_t t_fall;
    border_t t_final;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // A new string restarts length and border before this byte is placed
    assign len_eff = start_new ? '0 : len_reg;
    assign cb_eff  = start_new ? '0 : cb_reg;

    // Shared compare and fallback unit
    assign match   = (sym_reg == text_rd_reg);
    assign t_fall  = (border_rd_reg < t_reg) ? border_rd_reg : '0;
    assign t_final = match ? (t_reg + 1'b1) : '0;

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        cb_next         = cb_reg;
        t_next          = t_reg;
        sym_next        = sym_reg;
        res_border_next = res_border_reg;
        res_pos_next    = res_pos_reg;
        res_ovf_next    = res_ovf_reg;
        out_valid_next  = out_valid_reg && !out_xfer;
        mem_we          = 1'b0;
        wr_addr         = len_reg[ADDR_W-1:0];
        wr_sym          = sym_reg;
        wr_border       = t_final;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    len_next = len_eff;
                    cb_next  = cb_eff;
                    sym_next = symbol;
                    if (len_eff >= MAX_LEN)
                    begin
                        // Drop the byte, state holds
                        res_border_next = '0;
                        res_pos_next    = '0;
                        res_ovf_next    = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else if (len_eff == '0)
                    begin
                        // First byte of a string has no proper border
                        mem_we          = 1'b1;
                        wr_addr         = '0;
                        wr_sym          = symbol;
                        wr_border       = '0;
                        len_next        = len_t'(1);
                        cb_next         = '0;
                        res_border_next = '0;
                        res_pos_next    = len_t'(1);
                        res_ovf_next    = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        t_next     = ({1'b0, cb_eff} >= len_eff) ? '0 : cb_eff;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (match || (t_reg == '0))
                begin
                    // Border found (or none): store it and advance
                    mem_we          = 1'b1;
                    wr_border       = t_final;
                    cb_next         = t_final;
                    len_next        = len_reg + 1'b1;
                    res_border_next = t_final;
                    res_pos_next    = len_reg + 1'b1;
                    res_ovf_next    = 1'b0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    t_next     = t_fall;
                    state_next = ST_READ;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cb_reg        <= cb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        sym_reg        <= sym_next;
        res_border_reg <= res_border_next;
        res_pos_reg    <= res_pos_next;
        res_ovf_reg    <= res_ovf_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_border_reg <= res_border_reg;
            out_pos_reg    <= res_pos_reg;
            out_ovf_reg    <= res_ovf_reg;
        end
    end

    // Store port: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[wr_addr]   <= wr_sym;
            border_mem[wr_addr] <= wr_border;
        end
        if (state_reg == ST_READ)
        begin
            text_rd_reg   <= text_mem[t_reg[ADDR_W-1:0]];
            border_rd_reg <= border_mem[t_reg[ADDR_W-1:0] - 1'b1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign border_length = out_border_reg;
    assign position      = out_pos_reg;
    assign overflow      = out_ovf_reg;

`ifndef SYNTHESIS
    // Accepted byte goes to a probe or straight to hand-off
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_READ) || (state_reg == ST_DONE))
        else $error("accepted byte did not start processing");

    // Stored length never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MAX_LEN)
        else $error("string length beyond store depth");

    // A proper border is shorter than its prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ovf_reg) |-> ({1'b0, out_border_reg} < out_pos_reg))
        else $error("border not shorter than prefix");

    // Dropped byte reports an empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> (out_border_reg == '0) && (out_pos_reg == '0))
        else $error("overflow result not cleared");

    // Compare either falls back to another probe or finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (state_reg == ST_READ) || (state_reg == ST_DONE))
        else $error("compare step left the probe loop");
`endif

endmodule
